/* sv/utf8_decoder_with_substitution_assert.svh */
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODER_WITH_SUBSTITUTION_ASSERT_SVH
`define UTF8_DECODER_WITH_SUBSTITUTION_ASSERT_SVH

// same-cycle implication
`define UTFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/utfd_pkg.sv */
// ----------------------------------------------------------------------------
// utfd_pkg
// shared types and constants of the utf8 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package utfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN1 = 3'd1;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam logic [7:0]  QMARK       = 8'h3F;
  localparam logic [7:0]  MINUS_ASCII = 8'h2D;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_MIN4     = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [20:0] CP_MINUS    = 21'h002212;
  localparam logic [20:0] CP_FW_LO    = 21'h00FF01;
  localparam logic [20:0] CP_FW_HI    = 21'h00FF5E;
  localparam logic [20:0] CP_FW_OFS   = 21'h00FEE0;

  // one queued job: some substitute results, then optionally one character
  typedef struct packed {
    logic [2:0]  q_cnt;
    logic        tail_vld;
    logic [20:0] cp;
    logic [31:0] bytes;
    logic [2:0]  byte_cnt;
    logic [2:0]  used;
  } job_t;

endpackage

`default_nettype wire

/* sv/utfd_front.sv */
// ----------------------------------------------------------------------------
// utfd_front
// holds the pending sequence, classifies each byte and builds result jobs
// ----------------------------------------------------------------------------
`default_nettype none

module utfd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic           opcode,
  input  wire logic [7:0]     data_byte,
  output utfd_pkg::job_t      job,
  output logic                job_push
);

  logic [7:0]  lead_r, lead_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [1:0]  hc_r, hc_nxt;
  logic [11:0] hp_r, hp_nxt;

  logic [20:0] cp;
  logic [31:0] seq_bytes;
  logic        bad;
  logic        arabic;
  logic        do_start;
  logic [2:0]  lead_len;

  // assembled code point and raw bytes, valid when this byte completes a sequence
  always_comb begin
    case (len_r)
      utfd_pkg::SEQ_LEN2: begin
        cp        = {10'd0, lead_r[4:0], data_byte[5:0]};
        seq_bytes = {16'd0, data_byte, lead_r};
      end
      utfd_pkg::SEQ_LEN3: begin
        cp        = {5'd0, lead_r[3:0], hp_r[5:0], data_byte[5:0]};
        seq_bytes = {8'd0, data_byte, 2'b10, hp_r[5:0], lead_r};
      end
      default: begin
        cp        = {lead_r[2:0], hp_r, data_byte[5:0]};
        seq_bytes = {data_byte, 2'b10, hp_r[5:0], 2'b10, hp_r[11:6], lead_r};
      end
    endcase
    bad = ((len_r == utfd_pkg::SEQ_LEN3) &&
           ((cp < utfd_pkg::CP_MIN3) ||
            ((cp >= utfd_pkg::CP_SURR_LO) && (cp <= utfd_pkg::CP_SURR_HI)))) ||
          ((len_r == utfd_pkg::SEQ_LEN4) &&
           ((cp < utfd_pkg::CP_MIN4) || (cp > utfd_pkg::CP_MAX)));
    arabic = cp inside {[21'h0600:21'h06FF], [21'h0750:21'h077F], [21'h08A0:21'h08FF],
                        [21'hFB50:21'hFDFF], [21'hFE70:21'hFEFF]};
  end

  always_comb begin
    if (!data_byte[7]) begin
      lead_len = utfd_pkg::SEQ_LEN1;
    end else if (data_byte inside {[8'hC2:8'hDF]}) begin
      lead_len = utfd_pkg::SEQ_LEN2;
    end else if (data_byte inside {[8'hE0:8'hEF]}) begin
      lead_len = utfd_pkg::SEQ_LEN3;
    end else if (data_byte inside {[8'hF0:8'hF4]}) begin
      lead_len = utfd_pkg::SEQ_LEN4;
    end else begin
      lead_len = utfd_pkg::SEQ_NONE;
    end
  end

  always_comb begin
    job.q_cnt    = 3'd0;
    job.tail_vld = 1'b0;
    job.cp       = {13'd0, utfd_pkg::QMARK};
    job.bytes    = {24'd0, utfd_pkg::QMARK};
    job.byte_cnt = utfd_pkg::SEQ_LEN1;
    job.used     = utfd_pkg::SEQ_LEN1;
    lead_nxt     = lead_r;
    len_nxt      = len_r;
    hc_nxt       = hc_r;
    hp_nxt       = hp_r;
    do_start     = 1'b0;

    if (opcode == utfd_pkg::OP_FLUSH) begin
      if (len_r != utfd_pkg::SEQ_NONE) begin
        job.q_cnt = 3'd1 + {1'b0, hc_r};
        len_nxt   = utfd_pkg::SEQ_NONE;
        hc_nxt    = 2'd0;
        hp_nxt    = 12'd0;
        lead_nxt  = 8'd0;
      end
    end else if (len_r == utfd_pkg::SEQ_NONE) begin
      do_start = 1'b1;
    end else if (data_byte[7:6] != 2'b10) begin
      // broken sequence: flush what is held, then restart on this byte
      job.q_cnt = 3'd1 + {1'b0, hc_r};
      len_nxt   = utfd_pkg::SEQ_NONE;
      hc_nxt    = 2'd0;
      hp_nxt    = 12'd0;
      lead_nxt  = 8'd0;
      do_start  = 1'b1;
    end else if (({1'b0, hc_r} + 3'd2) < len_r) begin
      hp_nxt = {hp_r[5:0], data_byte[5:0]};
      hc_nxt = hc_r + 2'd1;
    end else begin
      len_nxt  = utfd_pkg::SEQ_NONE;
      hc_nxt   = 2'd0;
      hp_nxt   = 12'd0;
      lead_nxt = 8'd0;
      if (bad) begin
        job.q_cnt = 3'd2 + {1'b0, hc_r};
      end else begin
        job.tail_vld = 1'b1;
        job.used     = len_r;
        if (cp == utfd_pkg::CP_MINUS) begin
          job.cp    = {13'd0, utfd_pkg::MINUS_ASCII};
          job.bytes = {24'd0, utfd_pkg::MINUS_ASCII};
        end else if ((cp >= utfd_pkg::CP_FW_LO) && (cp <= utfd_pkg::CP_FW_HI)) begin
          job.cp    = cp - utfd_pkg::CP_FW_OFS;
          job.bytes = {24'd0, job.cp[7:0]};
        end else if (!arabic) begin
          job.cp       = cp;
          job.bytes    = seq_bytes;
          job.byte_cnt = len_r;
        end
      end
    end

    if (do_start) begin
      if (lead_len == utfd_pkg::SEQ_LEN1) begin
        job.tail_vld = 1'b1;
        job.cp       = {13'd0, data_byte};
        job.bytes    = {24'd0, data_byte};
      end else if (lead_len == utfd_pkg::SEQ_NONE) begin
        job.q_cnt = job.q_cnt + 3'd1;
      end else begin
        lead_nxt = data_byte;
        len_nxt  = lead_len;
        hc_nxt   = 2'd0;
        hp_nxt   = 12'd0;
      end
    end

    job_push = acc && ((job.q_cnt != 3'd0) || job.tail_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 8'd0;
      len_r  <= utfd_pkg::SEQ_NONE;
      hc_r   <= 2'd0;
      hp_r   <= 12'd0;
    end else if (acc) begin
      lead_r <= lead_nxt;
      len_r  <= len_nxt;
      hc_r   <= hc_nxt;
      hp_r   <= hp_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/utfd_queue.sv */
// ----------------------------------------------------------------------------
// utfd_queue
// small job queue between the classifier and the result sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module utfd_queue #(
  parameter int unsigned DEPTH = utfd_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  utfd_pkg::job_t      wr_job,
  input  wire logic           pop,
  output utfd_pkg::job_t      rd_job,
  output logic                full,
  output logic                nonempty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utfd_pkg::job_t slots_r [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == FULL_CNT);
  assign nonempty = (cnt_r != '0);
  assign rd_job   = slots_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

/* sv/utfd_back.sv */
// ----------------------------------------------------------------------------
// utfd_back
// expands jobs into result beats in the output register, one per popped cycle
// ----------------------------------------------------------------------------
`default_nettype none

module utfd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  utfd_pkg::job_t      head_job,
  input  wire logic           head_vld,
  output logic                head_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output logic [20:0]         out_code_point,
  output logic [31:0]         out_utf8_bytes,
  output logic [2:0]          out_byte_count,
  output logic [2:0]          out_consumed,
  output logic                out_last_of_run
);

  utfd_pkg::job_t job_r, job_nxt;
  logic           vld_r, vld_nxt;
  logic [2:0]     rem_r, rem_nxt;
  logic           is_last;
  logic           take;

  assign is_last = (rem_r == 3'd0) || ((rem_r == 3'd1) && !job_r.tail_vld);
  assign take    = !vld_r || (out_pop && is_last);

  always_comb begin
    out_empty       = !vld_r;
    out_last_of_run = is_last;
    if (rem_r != 3'd0) begin
      out_code_point = {13'd0, utfd_pkg::QMARK};
      out_utf8_bytes = {24'd0, utfd_pkg::QMARK};
      out_byte_count = utfd_pkg::SEQ_LEN1;
      out_consumed   = utfd_pkg::SEQ_LEN1;
    end else begin
      out_code_point = job_r.cp;
      out_utf8_bytes = job_r.bytes;
      out_byte_count = job_r.byte_cnt;
      out_consumed   = job_r.used;
    end
  end

  always_comb begin
    job_nxt  = job_r;
    vld_nxt  = vld_r;
    rem_nxt  = rem_r;
    head_pop = 1'b0;
    if (take) begin
      // job done or idle: load the next job straight from the queue head
      head_pop = head_vld;
      vld_nxt  = head_vld;
      job_nxt  = head_job;
      rem_nxt  = head_job.q_cnt;
    end else if (out_pop) begin
      rem_nxt = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

`include "utf8_decoder_with_substitution_assert.svh"

  `UTFD_ASSERT_NOW(a_tail_present, vld_r && (rem_r == 3'd0), job_r.tail_vld, "job without results")
  `UTFD_ASSERT_NOW(a_rem_bound, vld_r, rem_r <= 3'd4, "too many substitutes in one job")
  `UTFD_ASSERT_NEXT(a_run_continues, vld_r && out_pop && !is_last, vld_r, "run cut short")
  `UTFD_ASSERT_NEXT(a_idle_loads, !vld_r && head_vld, vld_r, "queued job not picked up")

endmodule

`default_nettype wire

/* sv/utf8_decoder_with_substitution.sv */
// ----------------------------------------------------------------------------
// utf8_decoder_with_substitution
// streaming utf8 decoder, one result per character, '?' for bad sequences
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  input     in_opcode, in_data_byte            in_push / in_full
//  result    out_code_point .. out_last_of_run  out_pop / out_empty
//
//  one byte is taken per cycle while the job queue has room
//  a byte's results are queued, then loaded into the output register
//  the result sequencer gives one beat per popped cycle; a failed sequence
//  gives up to four beats, so error bursts fill the queue and raise in_full
//  synchronous active-low reset clears the pending sequence and the queue
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decoder_with_substitution #(
  parameter int unsigned QUEUE_DEPTH = utfd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_opcode,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [20:0]      out_code_point,
  output logic [31:0]      out_utf8_bytes,
  output logic [2:0]       out_byte_count,
  output logic [2:0]       out_consumed,
  output logic             out_last_of_run
);

  utfd_pkg::job_t new_job, head_job;
  logic           acc;
  logic           job_push;
  logic           head_vld;
  logic           head_pop;

  assign acc = in_push && !in_full;

  utfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .job       (new_job),
    .job_push  (job_push)
  );

  utfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .wr_job   (new_job),
    .pop      (head_pop),
    .rd_job   (head_job),
    .full     (in_full),
    .nonempty (head_vld)
  );

  utfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .head_vld        (head_vld),
    .head_pop        (head_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_code_point  (out_code_point),
    .out_utf8_bytes  (out_utf8_bytes),
    .out_byte_count  (out_byte_count),
    .out_consumed    (out_consumed),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: utf8 decoder with substitution
// drives raw bytes and end-of-stream marks through the push/full side and
// checks every popped beat against a behavioral decoder kept in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 16;
  localparam int PRINT_LIMIT    = 60;

  // ranges that are replaced by '?'
  localparam logic [20:0] AR_MAIN_LO = 21'h000600;
  localparam logic [20:0] AR_MAIN_HI = 21'h0006FF;
  localparam logic [20:0] AR_SUP_LO  = 21'h000750;
  localparam logic [20:0] AR_SUP_HI  = 21'h00077F;
  localparam logic [20:0] AR_EXT_LO  = 21'h0008A0;
  localparam logic [20:0] AR_EXT_HI  = 21'h0008FF;
  localparam logic [20:0] AR_PFA_LO  = 21'h00FB50;
  localparam logic [20:0] AR_PFA_HI  = 21'h00FDFF;
  localparam logic [20:0] AR_PFB_LO  = 21'h00FE70;
  localparam logic [20:0] AR_PFB_HI  = 21'h00FEFF;

  typedef struct {
    logic        op;
    logic [7:0]  data;
  } byte_item_t;

  typedef struct {
    logic [20:0] cp;
    logic [31:0] bytes;
    logic [2:0]  cnt;
    logic [2:0]  used;
    logic        last;
  } char_beat_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_push      = 1'b0;
  logic        in_opcode    = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_pop      = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [20:0] out_code_point;
  logic [31:0] out_utf8_bytes;
  logic [2:0]  out_byte_count;
  logic [2:0]  out_consumed;
  logic        out_last_of_run;

  byte_item_t  pending_bytes[$];
  char_beat_t  expected_chars[$];
  char_beat_t  step_beats[$];

  // decoder state mirrored in the bench
  logic [7:0]  seq_lead    = 8'h00;
  logic [2:0]  seq_len     = utfd_pkg::SEQ_NONE;
  logic [1:0]  seq_held    = 2'd0;
  logic [17:0] seq_payload = 18'h0;

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int items_queued    = 0;
  int error_count     = 0;
  int quiet_cycles    = 0;
  int hold_count      = 0;
  bit long_hold_armed = 1'b0;
  bit long_hold_done  = 1'b0;

  utf8_decoder_with_substitution u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_code_point  (out_code_point),
    .out_utf8_bytes  (out_utf8_bytes),
    .out_byte_count  (out_byte_count),
    .out_consumed    (out_consumed),
    .out_last_of_run (out_last_of_run)
  );

  initial forever #4 clk = ~clk;

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("mismatch: %s", what);
  endtask

  // ---------------- decoder prediction ----------------

  function void add_beat(logic [20:0] cp, logic [31:0] bytes, logic [2:0] cnt,
                         logic [2:0] used);
    char_beat_t c;
    c.cp    = cp;
    c.bytes = bytes;
    c.cnt   = cnt;
    c.used  = used;
    c.last  = 1'b0;
    step_beats.push_back(c);
  endfunction

  function void clear_seq();
    seq_lead    = 8'h00;
    seq_len     = utfd_pkg::SEQ_NONE;
    seq_held    = 2'd0;
    seq_payload = 18'h0;
  endfunction

  // '?' for the lead plus one per held byte
  function void drop_seq(int held);
    add_beat(21'(utfd_pkg::QMARK), 32'(utfd_pkg::QMARK), 3'd1, 3'd1);
    for (int i = 0; i < held && i < 3; i++)
      add_beat(21'(utfd_pkg::QMARK), 32'(utfd_pkg::QMARK), 3'd1, 3'd1);
    clear_seq();
  endfunction

  function void open_lead(logic [7:0] b);
    logic [2:0] n;
    n = utfd_pkg::SEQ_NONE;
    if (b >= 8'hC2 && b <= 8'hDF) n = utfd_pkg::SEQ_LEN2;
    else if (b >= 8'hE0 && b <= 8'hEF) n = utfd_pkg::SEQ_LEN3;
    else if (b >= 8'hF0 && b <= 8'hF4) n = utfd_pkg::SEQ_LEN4;
    if (b < 8'h80) begin
      add_beat({13'h0, b}, {24'h0, b}, 3'd1, 3'd1);
    end else if (n == utfd_pkg::SEQ_NONE) begin
      add_beat(21'(utfd_pkg::QMARK), 32'(utfd_pkg::QMARK), 3'd1, 3'd1);
    end else begin
      seq_lead    = b;
      seq_len     = n;
      seq_held    = 2'd0;
      seq_payload = 18'h0;
    end
  endfunction

  function bit is_arabic(logic [20:0] cp);
    return (cp >= AR_MAIN_LO && cp <= AR_MAIN_HI) || (cp >= AR_SUP_LO && cp <= AR_SUP_HI) ||
           (cp >= AR_EXT_LO && cp <= AR_EXT_HI) || (cp >= AR_PFA_LO && cp <= AR_PFA_HI) ||
           (cp >= AR_PFB_LO && cp <= AR_PFB_HI);
  endfunction

  function void finish_seq(logic [7:0] b);
    logic [20:0] cp;
    logic [20:0] ascii;
    logic [7:0]  lmask;
    logic [31:0] bytes;
    logic [5:0]  p;
    lmask = (seq_len == utfd_pkg::SEQ_LEN2) ? 8'h1F :
            (seq_len == utfd_pkg::SEQ_LEN3) ? 8'h0F : 8'h07;
    cp = (21'(seq_lead & lmask) << (6 * (seq_len - 1))) | (21'(seq_payload) << 6) |
         21'(b[5:0]);
    if ((seq_len == utfd_pkg::SEQ_LEN3 &&
         (cp < utfd_pkg::CP_MIN3 ||
          (cp >= utfd_pkg::CP_SURR_LO && cp <= utfd_pkg::CP_SURR_HI))) ||
        (seq_len == utfd_pkg::SEQ_LEN4 &&
         (cp < utfd_pkg::CP_MIN4 || cp > utfd_pkg::CP_MAX))) begin
      drop_seq(int'(seq_held) + 1);
      return;
    end
    if (cp == utfd_pkg::CP_MINUS ||
        (cp >= utfd_pkg::CP_FW_LO && cp <= utfd_pkg::CP_FW_HI)) begin
      ascii = (cp == utfd_pkg::CP_MINUS) ? 21'(utfd_pkg::MINUS_ASCII) :
              cp - utfd_pkg::CP_FW_OFS;
      add_beat(ascii, 32'(ascii), 3'd1, seq_len);
    end else if (is_arabic(cp)) begin
      add_beat(21'(utfd_pkg::QMARK), 32'(utfd_pkg::QMARK), 3'd1, seq_len);
    end else begin
      bytes = {24'h0, seq_lead};
      for (int i = 0; i < seq_held; i++) begin
        p = 6'(seq_payload >> (6 * (seq_held - 1 - i)));
        bytes = bytes | ({24'h0, 2'b10, p} << (8 * (i + 1)));
      end
      bytes = bytes | ({24'h0, b} << (8 * (seq_held + 1)));
      add_beat(cp, bytes, seq_len, seq_len);
    end
    clear_seq();
  endfunction

  function void decode_byte(logic op, logic [7:0] b);
    char_beat_t c;
    step_beats.delete();
    if (op == utfd_pkg::OP_FLUSH) begin
      if (seq_len != utfd_pkg::SEQ_NONE) drop_seq(int'(seq_held));
    end else if (seq_len == utfd_pkg::SEQ_NONE) begin
      open_lead(b);
    end else if (b[7:6] != 2'b10) begin
      drop_seq(int'(seq_held));
      open_lead(b);
    end else if (seq_held + 2 < seq_len) begin
      seq_payload = {seq_payload[11:0], b[5:0]};
      seq_held    = seq_held + 2'd1;
    end else begin
      finish_seq(b);
    end
    if (step_beats.size() > 0) begin
      c = step_beats.pop_back();
      c.last = 1'b1;
      step_beats.push_back(c);
    end
    foreach (step_beats[i]) expected_chars.push_back(step_beats[i]);
  endfunction

  // ---------------- stimulus ----------------

  function void put_item(logic op, logic [7:0] data);
    byte_item_t it;
    it.op   = op;
    it.data = data;
    pending_bytes.push_back(it);
    items_queued++;
  endfunction

  // encodes cp in n bytes (overlong when n is too big) and queues the first keep
  function void put_char(logic [20:0] cp, int n, int keep);
    logic [7:0] enc [4];
    case (n)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep && i < n; i++) put_item(utfd_pkg::OP_DATA, enc[i]);
  endfunction

  function int natural_len(logic [20:0] cp);
    return (cp < 21'h80) ? 1 : (cp < utfd_pkg::CP_MIN3) ? 2 :
           (cp < utfd_pkg::CP_MIN4) ? 3 : 4;
  endfunction

  function logic [20:0] border_cp(int k);
    case (k)
      0:  return 21'h00007F;
      1:  return 21'h000080;
      2:  return 21'h0007FF;
      3:  return 21'h000800;
      4:  return 21'h00D7FF;
      5:  return 21'h00E000;
      6:  return 21'h00FFFF;
      7:  return 21'h010000;
      8:  return 21'h10FFFF;
      9:  return 21'h002211;
      10: return 21'h002213;
      11: return 21'h00FF00;
      12: return 21'h00FF5F;
      13: return 21'h0005FF;
      14: return 21'h000700;
      15: return 21'h00074F;
      16: return 21'h000780;
      17: return 21'h00089F;
      18: return 21'h00FB4F;
      default: return 21'h00FE6F;
    endcase
  endfunction

  function logic [20:0] special_cp();
    case ($urandom_range(8, 0))
      0: return utfd_pkg::CP_MINUS;
      1: return 21'($urandom_range(utfd_pkg::CP_FW_HI, utfd_pkg::CP_FW_LO));
      2: return 21'($urandom_range(AR_MAIN_HI, AR_MAIN_LO));
      3: return 21'($urandom_range(AR_SUP_HI, AR_SUP_LO));
      4: return 21'($urandom_range(AR_EXT_HI, AR_EXT_LO));
      5: return 21'($urandom_range(AR_PFA_HI, AR_PFA_LO));
      6: return 21'($urandom_range(AR_PFB_HI, AR_PFB_LO));
      7: return 21'($urandom_range(utfd_pkg::CP_SURR_HI, utfd_pkg::CP_SURR_LO));
      default: return border_cp($urandom_range(19, 0));
    endcase
  endfunction

  function void gen_random_char();
    logic [20:0] cp;
    int          kind;
    int          n;
    kind = $urandom_range(99, 0);
    if (kind < 18) begin
      put_item(utfd_pkg::OP_DATA, 8'($urandom_range(127, 0)));
    end else if (kind < 36) begin
      put_char(21'($urandom_range(21'h7FF, 21'h80)), 2, 2);
    end else if (kind < 50) begin
      put_char(21'($urandom_range(21'hFFFF, 21'h800)), 3, 3);
    end else if (kind < 60) begin
      put_char(21'($urandom_range(utfd_pkg::CP_MAX, utfd_pkg::CP_MIN4)), 4, 4);
    end else if (kind < 74) begin
      cp = special_cp();
      n  = natural_len(cp);
      put_char(cp, n, n);
    end else if (kind < 81) begin
      // overlong or beyond the code space
      case ($urandom_range(3, 0))
        0: put_char(21'($urandom_range(21'h7FF, 0)), 3, 3);
        1: put_char(21'($urandom_range(21'hFFFF, 0)), 4, 4);
        2: put_char(21'($urandom_range(21'h13FFFF, 21'h110000)), 4, 4);
        default: put_char(21'($urandom_range(21'h7F, 0)), 2, 2);
      endcase
    end else if (kind < 91) begin
      // truncated sequence, then a stream end or some other byte
      n = $urandom_range(4, 2);
      cp = (n == 2) ? 21'($urandom_range(21'h7FF, 21'h80)) :
           (n == 3) ? 21'($urandom_range(21'hFFFF, 21'h800)) :
           21'($urandom_range(utfd_pkg::CP_MAX, utfd_pkg::CP_MIN4));
      put_char(cp, n, $urandom_range(n - 1, 1));
      if ($urandom_range(1, 0) == 0) put_item(utfd_pkg::OP_FLUSH, 8'($urandom_range(255, 0)));
      else put_item(utfd_pkg::OP_DATA, 8'($urandom_range(255, 0)));
    end else if ($urandom_range(3, 0) == 0) begin
      put_item(utfd_pkg::OP_FLUSH, 8'($urandom_range(255, 0)));
    end else begin
      put_item(utfd_pkg::OP_DATA, 8'($urandom_range(255, 0)));
    end
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    bit took;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      took = in_push && !in_full;
      if (took) begin
        decode_byte(in_opcode, in_data_byte);
        void'(pending_bytes.pop_front());
      end
      if (in_push && !took) begin
        // keep offering the same beat
      end else if (pending_bytes.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_push      <= 1'b1;
        in_opcode    <= pending_bytes[0].op;
        in_data_byte <= pending_bytes[0].data;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_chars.size() == 0) begin
          flag_error($sformatf("unexpected beat cp=%h bytes=%h", out_code_point,
                               out_utf8_bytes));
        end else begin
          want = expected_chars.pop_front();
          if (out_code_point !== want.cp)
            flag_error($sformatf("code_point %h, want %h", out_code_point, want.cp));
          if (out_utf8_bytes !== want.bytes)
            flag_error($sformatf("utf8_bytes %h, want %h", out_utf8_bytes, want.bytes));
          if (out_byte_count !== want.cnt)
            flag_error($sformatf("byte_count %0d, want %0d", out_byte_count, want.cnt));
          if (out_consumed !== want.used)
            flag_error($sformatf("consumed %0d, want %0d", out_consumed, want.used));
          if (out_last_of_run !== want.last)
            flag_error($sformatf("last_of_run %b, want %b", out_last_of_run, want.last));
        end
      end
      if (long_hold_armed && !long_hold_done) begin
        // long back-pressure so the job queue fills and in_full rises
        hold_count++;
        if (hold_count >= LONG_HOLD) long_hold_done = 1'b1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 29 : 0;
      if (phase == 0) begin
        put_item(utfd_pkg::OP_DATA, 8'h00);
        put_item(utfd_pkg::OP_DATA, 8'hFF);     // invalid lead
        put_char(21'h000080, 2, 2);
        put_char(utfd_pkg::CP_MINUS, 3, 3);
        put_char(utfd_pkg::CP_FW_HI, 3, 3);
        put_char(utfd_pkg::CP_SURR_LO, 3, 3);
        put_char(21'h110000, 4, 4);             // past the code space
        put_char(21'h0007FF, 3, 3);             // overlong
        put_item(utfd_pkg::OP_DATA, 8'hC2);     // lead cut by a plain byte
        put_item(utfd_pkg::OP_DATA, 8'h41);
        put_char(utfd_pkg::CP_MAX, 4, 3);       // stream end mid sequence
        put_item(utfd_pkg::OP_FLUSH, 8'hFF);
        put_item(utfd_pkg::OP_FLUSH, 8'h00);    // nothing pending
        put_char(21'h000627, 2, 2);
      end else if (phase == 2) begin
        long_hold_armed = 1'b1;
      end
      while (items_queued < 110 * (phase + 1)) gen_random_char();
      while (pending_bytes.size() > 0 || expected_chars.size() > 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0)
      flag_error($sformatf("%0d beats never arrived", expected_chars.size()));
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* utf8_decoder_with_substitution.f */
+incdir+sv
sv/utfd_pkg.sv
sv/utfd_front.sv
sv/utfd_queue.sv
sv/utfd_back.sv
sv/utf8_decoder_with_substitution.sv
tb/sv/tb.sv
